>>> hdl/kti_pkg.sv
// Keyframe track interpolator: shared types and constants.
// No dependencies.
package kti_pkg;
    typedef enum logic [1:0] {
        OP_WR_TIME  = 2'd0,
        OP_WR_VALUE = 2'd1,
        OP_QUERY    = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    localparam logic [7:0] CFG_FRAME_COUNT = 8'd0;
    localparam logic [7:0] CFG_ELEMS       = 8'd1;
    localparam int RESULT_LIMIT = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_T0_RD,
        ST_T0_WAIT,
        ST_DIV,
        ST_V_RD0,
        ST_V_RD1,
        ST_V_WAIT,
        ST_MUL,
        ST_MUL_HI,
        ST_SAT,
        ST_OUT
    } state_t;
endpackage

>>> hdl/kti_divider.sv
// Keyframe track interpolator: restoring divider, one quotient bit a cycle.
// No dependencies.
module kti_divider #(
    parameter int NW = 50,
    parameter int DW = 33
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NW-1:0]        num_mag,
    input  logic [DW-1:0]        den_mag,
    output logic                 done,
    output logic [NW-1:0]        quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start) begin
            quo_next  = num_mag;
            rem_next  = '0;
            den_next  = den_mag;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) busy_reg <= 1'b0;
        else busy_reg <= busy_next;
    end

    // The final quotient bit settles in the cycle that raises done.
    assign done = busy_reg && !busy_next && !start;
    assign quo  = quo_next;
endmodule

>>> hdl/keyframe_track_interpolator_top.sv
// Keyframe track interpolator. Writes are accepted in idle and leave it idle. A query
// is accepted, walks the key times (read, compare) to the first key at or after the
// query time or the last frame, fetches t0, runs the serial divider (skipped when the
// span is zero), then per element, plus output stalls: two value-memory reads,
// difference, two multiply steps, saturate, output. One request at a time.
// Synchronous active-low reset clears control and config; memories are not cleared.
module keyframe_track_interpolator_top #(
    parameter int MAX_FRAMES = 256,
    parameter int MAX_ELEMS  = 4,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], frame_index[9:2], elem_index[11:10], word_value[43:12],
    // query_time[75:44], zero pad [79:76]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample_value[31:0], sample_elem[33:32], zero pad [39:34]
    output logic [39:0] m_tdata,
    // last_elem
    output logic        m_tlast
);
    import kti_pkg::*;

    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int EW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int NW = FRAC_BITS + 34;
    localparam int TW = FRAC_BITS + 35;
    localparam int PW = FRAC_BITS + 69;
    localparam int LW = 26;
    localparam int ELIM = (MAX_ELEMS < RESULT_LIMIT) ? MAX_ELEMS : RESULT_LIMIT;

    // Unpack the request.
    logic [1:0]         in_op;
    logic [7:0]         in_fi;
    logic [1:0]         in_ei;
    logic signed [31:0] in_word, in_q;
    assign in_op   = s_tdata[1:0];
    assign in_fi   = s_tdata[9:2];
    assign in_ei   = s_tdata[11:10];
    assign in_word = s_tdata[43:12];
    assign in_q    = s_tdata[75:44];

    logic [8:0] fc_reg;
    logic [2:0] ne_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= 9'd2;
            ne_reg <= 3'd1;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_FRAME_COUNT) fc_reg <= cfg_data[8:0];
            else if (cfg_index == CFG_ELEMS) ne_reg <= cfg_data[2:0];
        end
    end

    // Clamped counts.
    logic [16:0] fc_eff;
    logic [4:0]  ne_eff;
    always_comb begin
        fc_eff = 17'(fc_reg);
        if (fc_eff < 17'd2) fc_eff = 17'd2;
        if (fc_eff > 17'(MAX_FRAMES)) fc_eff = 17'(MAX_FRAMES);
        ne_eff = 5'(ne_reg);
        if (ne_eff < 5'd1) ne_eff = 5'd1;
        if (ne_eff > 5'(ELIM)) ne_eff = 5'(ELIM);
    end

    // Memories.
    logic [31:0] tmem [MAX_FRAMES];
    logic [31:0] vmem [MAX_FRAMES * (1 << EW)];
    logic [FW-1:0]    t_raddr;
    logic [FW+EW-1:0] v_raddr;
    logic [31:0]      t_rdata, v_rdata;
    logic in_acc;
    assign in_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_acc && in_op == OP_WR_TIME && 32'(in_fi) < 32'(MAX_FRAMES))
            tmem[FW'(in_fi)] <= in_word;
        t_rdata <= tmem[t_raddr];
    end
    always_ff @(posedge aclk) begin
        if (in_acc && in_op == OP_WR_VALUE && 32'(in_fi) < 32'(MAX_FRAMES)
            && 32'(in_ei) < 32'(MAX_ELEMS))
            vmem[{FW'(in_fi), EW'(in_ei)}] <= in_word;
        v_rdata <= vmem[v_raddr];
    end

    state_t state_reg, state_next;
    logic signed [31:0] q_reg, t1_reg, t0_reg, v0_reg;
    logic [FW-1:0] cur_reg, prv_reg;
    logic [EW-1:0] e_reg;
    logic [4:0]    ecnt_reg;
    logic signed [FRAC_BITS+34:0] t_reg;
    logic signed [31:0] res_reg;
    logic          last_reg;
    logic [1:0]    oel_reg;
    logic          ovalid_reg;
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [32:0]   div_den;
    logic          tneg_reg;
    logic signed [32:0] dnum, dden, diff;
    logic signed [32:0] diff_reg;
    logic          cmp_ge, at_last;

    assign cmp_ge  = $signed(t_rdata) >= q_reg;
    assign at_last = 17'(cur_reg) == fc_eff - 17'd1;
    assign dnum = 33'(q_reg) - 33'(t0_reg);
    assign dden = 33'(t1_reg) - 33'(t0_reg);
    assign div_num = NW'(dnum[32] ? -dnum : dnum) << FRAC_BITS;
    assign div_den = dden[32] ? 33'(-dden) : 33'(dden);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_acc && in_op == OP_QUERY) state_next = ST_SRCH_RD;
            ST_SRCH_RD:  state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: if (cmp_ge || at_last) state_next = ST_T0_RD;
                         else state_next = ST_SRCH_RD;
            ST_T0_RD:    state_next = ST_T0_WAIT;
            ST_T0_WAIT:  state_next = ST_DIV;
            ST_DIV:      if (dden == 33'sd0 || div_done) state_next = ST_V_RD0;
            ST_V_RD0:    state_next = ST_V_RD1;
            ST_V_RD1:    state_next = ST_V_WAIT;
            ST_V_WAIT:   state_next = ST_MUL;
            ST_MUL:      state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_SAT;
            ST_SAT:      state_next = ST_OUT;
            ST_OUT:      if (!ovalid_reg || m_tready)
                             state_next = last_reg ? ST_IDLE : ST_V_RD0;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    logic div_started_reg;
    always_comb begin
        t_raddr   = cur_reg;
        v_raddr   = {prv_reg, e_reg};
        div_start = 1'b0;
        case (state_reg)
            ST_T0_RD: t_raddr = prv_reg;
            ST_DIV:   div_start = !div_started_reg && dden != 33'sd0;
            ST_V_RD1: v_raddr = {cur_reg, e_reg};
            default: ;
        endcase
    end

    kti_divider #(.NW(NW), .DW(33)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num_mag(div_num), .den_mag(div_den), .done(div_done), .quo(div_quo)
    );

    // Multiply in two halves of t and round: delta = floor(diff * t / 2^F), saturate.
    logic signed [PW-1:0] pp_lo, pp_hi, acc_reg;
    logic signed [FRAC_BITS+68:0] sum;
    assign diff  = 33'($signed(v_rdata)) - 33'(v0_reg);
    assign pp_lo = PW'(diff_reg * $signed({1'b0, t_reg[LW-1:0]}));
    assign pp_hi = PW'(diff_reg * $signed(t_reg[TW-1:LW]));
    assign sum   = (FRAC_BITS+69)'(v0_reg) + (acc_reg >>> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ovalid_reg      <= 1'b0;
            div_started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && m_tready && state_reg != ST_OUT) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    q_reg    <= in_q;
                    cur_reg  <= '0;
                    e_reg    <= '0;
                    ecnt_reg <= 5'd0;
                    div_started_reg <= 1'b0;
                end
                ST_SRCH_CMP: begin
                    t1_reg <= t_rdata;
                    if (cmp_ge || at_last) prv_reg <= (cur_reg == '0) ? '0 : cur_reg - 1'b1;
                    else cur_reg <= cur_reg + 1'b1;
                end
                ST_T0_WAIT: t0_reg <= t_rdata;
                ST_DIV: begin
                    if (div_start) begin
                        div_started_reg <= 1'b1;
                        tneg_reg <= dnum[32] ^ dden[32];
                    end
                    if (dden == 33'sd0) t_reg <= '0;
                    else if (div_done)
                        t_reg <= tneg_reg ? -(FRAC_BITS+35)'(div_quo)
                                          : (FRAC_BITS+35)'(div_quo);
                end
                ST_V_RD1: v0_reg <= v_rdata;
                ST_V_WAIT: diff_reg <= diff;
                ST_MUL: acc_reg <= pp_lo;
                ST_MUL_HI: acc_reg <= acc_reg + (pp_hi <<< LW);
                ST_SAT: begin
                    // |t| <= 2^(F+32), |diff| <= 2^33: product fits, saturate.
                    if (sum > (FRAC_BITS+69)'(64'sd2147483647)) res_reg <= 32'h7fffffff;
                    else if (sum < -(FRAC_BITS+69)'(64'sd2147483648)) res_reg <= 32'h80000000;
                    else res_reg <= sum[31:0];
                    oel_reg  <= 2'(e_reg);
                    last_reg <= ecnt_reg + 5'd1 == ne_eff;
                end
                ST_OUT: if (!ovalid_reg || m_tready) begin
                    ovalid_reg <= 1'b1;
                    m_tdata    <= {6'd0, oel_reg, res_reg};
                    m_tlast    <= last_reg;
                    e_reg      <= e_reg + 1'b1;
                    ecnt_reg   <= ecnt_reg + 5'd1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = ovalid_reg;
    assign s_tready = state_reg == ST_IDLE;

`ifndef SYNTHESIS
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready) else $error("accepted while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_query_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == OP_QUERY |=> state_reg == ST_SRCH_RD)
        else $error("query not started");
`endif
endmodule

>>> tb/kti_checker.sv
`timescale 1ns / 1ps
// Result checker for the keyframe track interpolator: mirrors the key track and
// the registers from the observed requests and compares every sample. Uses kti_pkg.
module kti_checker
    import kti_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          pending_samples,
    output int          mismatch_count
);
    localparam int NFRAMES = 256;
    localparam int NELEMS  = 4;
    localparam int FRAC    = 16;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  elem;
        logic        last;
    } sample_t;

    logic [31:0] track_times [NFRAMES];
    logic [31:0] track_values [NFRAMES*NELEMS];
    logic [8:0]  frame_count_q;
    logic [2:0]  elems_q;
    sample_t     sample_queue [$];

    assign pending_samples = sample_queue.size();

    initial mismatch_count = 0;

    task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
        mismatch_count++;
    endtask

    function automatic logic [31:0] saturate(input longint x);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    // Blend factor t is Q16 of (q-t0)/(t1-t0); delta is floored, magnitude-capped.
    function automatic logic [31:0] blend(input longint v0, input longint v1,
                                          input longint t0, input longint t1,
                                          input longint q);
        longint den, t, diff, delta;
        longint unsigned ad, at, up, cap;
        bit neg;
        den  = t1 - t0;
        t    = 0;
        diff = v1 - v0;
        cap  = 64'h4000_0000_0000_0000;
        if (den != 0) t = ((q - t0) * (64'sd1 <<< FRAC)) / den;
        if (diff == 0 || t == 0) return saturate(v0);
        ad  = (diff < 0) ? -diff : diff;
        at  = (t < 0) ? -t : t;
        neg = (diff < 0) != (t < 0);
        if (at > cap / ad) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        up = ad * at;
        if (neg) delta = -longint'((up + ((64'd1 << FRAC) - 1)) >> FRAC);
        else delta = longint'(up >> FRAC);
        return saturate(v0 + delta);
    endfunction

    task automatic predict_query(input logic [31:0] qt);
        int fc, ne, cur, prev;
        longint q, t0, t1;
        sample_t s;
        fc = (frame_count_q < 2) ? 2 : (frame_count_q > NFRAMES ? NFRAMES : frame_count_q);
        ne = (elems_q < 1) ? 1 : (elems_q > NELEMS ? NELEMS : elems_q);
        q = longint'(signed'(qt));
        cur = 0;
        while (cur < fc && longint'(signed'(track_times[cur])) < q) cur++;
        if (cur >= fc) cur = fc - 1;
        prev = (cur == 0) ? 0 : cur - 1;
        t0 = longint'(signed'(track_times[prev]));
        t1 = longint'(signed'(track_times[cur]));
        for (int e = 0; e < ne; e++) begin
            s.value = blend(longint'(signed'(track_values[prev*NELEMS+e])),
                            longint'(signed'(track_values[cur*NELEMS+e])), t0, t1, q);
            s.elem  = e[1:0];
            s.last  = (e == ne - 1);
            sample_queue.push_back(s);
        end
    endtask

    always @(posedge aclk) begin
        sample_t s;
        op_t op;
        if (!aresetn) begin
            frame_count_q <= 9'd2;
            elems_q       <= 3'd1;
            sample_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_COUNT) frame_count_q <= cfg_data[8:0];
                else if (cfg_index == CFG_ELEMS) elems_q <= cfg_data[2:0];
            end
            if (s_tvalid && s_tready) begin
                op = op_t'(s_tdata[1:0]);
                case (op)
                    OP_WR_TIME: track_times[s_tdata[9:2]] = s_tdata[43:12];
                    OP_WR_VALUE: track_values[s_tdata[9:2]*NELEMS + s_tdata[11:10]] = s_tdata[43:12];
                    OP_QUERY: predict_query(s_tdata[75:44]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (sample_queue.size() == 0) begin
                    report("unexpected sample", 32'h0, m_tdata[31:0]);
                end else begin
                    s = sample_queue.pop_front();
                    if (m_tdata[31:0] !== s.value) report("sample_value", s.value, m_tdata[31:0]);
                    if (m_tdata[33:32] !== s.elem) report("sample_elem", 32'(s.elem), 32'(m_tdata[33:32]));
                    if (m_tlast !== s.last) report("last_elem", 32'(s.last), 32'(m_tlast));
                end
            end
        end
    end
endmodule

>>> tb/tb_keyframe_track_interpolator_top.sv
`timescale 1ns / 1ps
// Testbench top for keyframe_track_interpolator_top: drives track loads, queries
// and register writes with random gaps. Uses kti_pkg and kti_checker.
module tb_keyframe_track_interpolator_top;
    import kti_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int pending_samples;
    int mismatch_count;
    bit steady_flow = 1'b0;       // when set, neither side idles
    int stall_left = 0;
    logic [31:0] shadow_times [256];
    int live_frames;
    int track_span = 2;

    // Block's own worst query: full search over 256 keys, divider, four elements.
    localparam int DRAIN_CYCLES = 800;
    // Frames actually loaded per phase; a larger count ends on a top key time.
    localparam int TRACK_FRAMES = 4;

    keyframe_track_interpolator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    kti_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .pending_samples(pending_samples), .mismatch_count(mismatch_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Result side: hold tready low for random stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            if (!steady_flow) stall_left <= pick_gap();
        end
    end

    // Present one request and hold it until accepted; tready is sampled mid-cycle.
    task automatic send_request(input op_t op, input logic [7:0] frame, input logic [1:0] elem,
                                input logic [31:0] word, input logic [31:0] qtime);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, qtime, word, elem, frame, op};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        if (op == OP_WR_TIME) shadow_times[frame] = word;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, let every sample drain, then give the block time to settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_samples != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 2))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    // Load ascending key times and the elements in use of the first few frames.
    // With more frames in use, the last loaded frame holds the top key time, so
    // a search never walks past it.
    task automatic load_track(input int frames, input int elems);
        longint step_max, tcur;
        int loaded;
        loaded = (frames > TRACK_FRAMES) ? TRACK_FRAMES : frames;
        step_max = 64'sd4294967295 / loaded;
        tcur = -64'sd2147483648 + $urandom_range(0, 1000);
        for (int f = 0; f < loaded; f++) begin
            if (frames > loaded && f == loaded - 1) tcur = 64'sd2147483647;
            send_request(OP_WR_TIME, f[7:0], 2'd0, tcur[31:0], $urandom());
            for (int e = 0; e < elems; e++)
                send_request(OP_WR_VALUE, f[7:0], e[1:0], random_value(), $urandom());
            tcur = tcur + $urandom_range(0, int'(step_max - 1));
        end
        live_frames = loaded;
        track_span  = frames;
    endtask

    function automatic logic [31:0] pick_query_time();
        int k;
        longint a, b;
        k = $urandom_range(0, live_frames - 2);
        a = longint'(signed'(shadow_times[k]));
        b = longint'(signed'(shadow_times[k+1]));
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return shadow_times[$urandom_range(0, live_frames - 1)];
            default: begin
                if (b < a) return shadow_times[k];
                return 32'(a + longint'($urandom()) % (b - a + 1));
            end
        endcase
    endfunction

    // Random traffic: mostly queries, some rewrites anywhere, a little ignored noise.
    // Keep time rewrites off the top key and the unloaded frames a search can reach.
    task automatic random_traffic(input int count);
        int r;
        logic [7:0] frame;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 72)
                send_request(OP_QUERY, 8'($urandom()), 2'($urandom()), $urandom(),
                             pick_query_time());
            else if (r < 80) begin
                frame = 8'($urandom());
                if (track_span > live_frames && frame >= live_frames - 1 && frame < track_span)
                    frame = 8'($urandom_range(0, live_frames - 2));
                send_request(OP_WR_TIME, frame, 2'($urandom()), $urandom(), $urandom());
            end else if (r < 92)
                send_request(OP_WR_VALUE, 8'($urandom()), 2'($urandom()), random_value(),
                             $urandom());
            else
                send_request(OP_NONE, 8'($urandom()), 2'($urandom()), $urandom(), $urandom());
        end
    endtask

    task automatic run_phase(input logic [31:0] fc_raw, input logic [31:0] ne_raw, input int count);
        int frames;
        int elems;
        write_reg(CFG_FRAME_COUNT, fc_raw);
        write_reg(CFG_ELEMS, ne_raw);
        frames = (fc_raw[8:0] < 2) ? 2 : (fc_raw[8:0] > 256 ? 256 : int'(fc_raw[8:0]));
        elems  = (ne_raw[2:0] < 1) ? 1 : (ne_raw[2:0] > 4 ? 4 : int'(ne_raw[2:0]));
        load_track(frames, elems);
        random_traffic(count);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: three frames at the time extremes and zero, four elements each.
        write_reg(CFG_FRAME_COUNT, 32'd3);
        write_reg(CFG_ELEMS, 32'd4);
        send_request(OP_WR_TIME, 8'd0, 2'd0, 32'h8000_0000, 32'h0);
        send_request(OP_WR_TIME, 8'd1, 2'd0, 32'h0000_0000, 32'h0);
        send_request(OP_WR_TIME, 8'd2, 2'd0, 32'h7fff_ffff, 32'h0);
        for (int f = 0; f < 3; f++)
            for (int e = 0; e < 4; e++)
                send_request(OP_WR_VALUE, f[7:0], e[1:0],
                             (e[0] ^ f[0]) ? 32'h7fff_ffff : 32'h8000_0000, 32'h0);
        live_frames = 3;
        track_span  = 3;
        // On the first key, on the middle key, between with a huge span, at the top.
        send_request(OP_QUERY, 8'hff, 2'd3, 32'hffff_ffff, 32'h8000_0000);
        send_request(OP_QUERY, 8'h00, 2'd0, 32'h0, 32'h0000_0000);
        send_request(OP_QUERY, 8'h00, 2'd0, 32'h0, 32'h4000_0000);
        send_request(OP_QUERY, 8'h00, 2'd0, 32'h0, 32'h7fff_ffff);
        // Equal key times at the end: zero span, clamp to last frame.
        send_request(OP_WR_TIME, 8'd2, 2'd0, 32'h0000_0000, 32'h0);
        send_request(OP_QUERY, 8'h00, 2'd0, 32'h0, 32'h0000_0005);
        send_request(OP_NONE, 8'hff, 2'd3, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        // Register extremes, clamped values, and a phase without idling.
        run_phase(32'd2, 32'd1, 6);
        steady_flow = 1'b1;
        run_phase(32'd4, 32'd3, 6);
        steady_flow = 1'b0;
        run_phase(32'd0, 32'd0, 6);
        run_phase(32'hffff_ffff, 32'hffff_ffff, 6);
        run_phase(32'd9, 32'd2, 6);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
